// ===== src/assert_macros.svh =====
// Assertion macros shared by the patch evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define BBPE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication checked on every rising edge outside reset.
`define BBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== src/bbpe_pkg.sv =====
// Types and constants shared by the Bezier patch evaluator modules.
package bbpe_pkg;

  localparam int CTRL_SIDE = 4;
  localparam int NPTS      = CTRL_SIDE * CTRL_SIDE;
  localparam int ONE_Q12   = 4096;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Shift-subtract unit widths.
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W  = 34;
  localparam int QUO_W  = 16;

  // Accumulator width for the surface sums.
  localparam int ACC_W = 52;

  // Configuration register index.
  localparam logic REG_CELLS = 1'b0;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_TICK = 2'd1,
    ACT_EVAL = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } shu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } shu_stat_t;

endpackage

// ===== src/bicubic_bezier_patch_evaluator.sv =====
// Top level: control point stores, sequencer and result register of the patch evaluator.
// Load writes one control point. Tick updates every control point, first its velocity,
// then its height, on the shared multiplier. Evaluate runs on the one shared multiplier
// (60 products) and the bit-serial shift-subtract unit (five divisions and one 31-step
// square root).
// One item at a time; reset clears both stores to zero and sets cells_per_side to 16.
`include "assert_macros.svh"
module bicubic_bezier_patch_evaluator #(
  parameter int GRID_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_index[3:0], height[19:4], rate[35:20], time_step[51:36],
  // grid_col[58:52], grid_row[65:59], zero fill above
  input  logic [71:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_u[15:0], pos_v[31:16], surface_z[47:32], normal_x[63:48],
  // normal_y[79:64], normal_z[95:80]
  output logic [95:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bbpe_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TICK   = 9'b000000010,
    ST_DIVUV  = 9'b000000100,
    ST_BASIS  = 9'b000001000,
    ST_ROWS   = 9'b000010000,
    ST_SQUARE = 9'b000100000,
    ST_SQRT   = 9'b001000000,
    ST_NORM   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  state_t state;
  logic        phase;
  logic [3:0]  cnt;
  logic [1:0]  row;
  logic [1:0]  sel;

  logic [6:0]  cells;
  logic [6:0]  cells_eff;
  logic [6:0]  lat_col;
  logic [6:0]  lat_row;
  logic [15:0] lat_dt;

  logic signed [15:0] hs [NPTS];
  logic signed [15:0] vs [NPTS];

  logic [15:0] pos_u;
  logic [15:0] pos_v;
  logic [30:0] s2;
  logic [30:0] t2;
  logic [30:0] st;
  logic signed [17:0] bas_b [2][CTRL_SIDE];
  logic signed [17:0] bas_d [2][CTRL_SIDE];
  logic signed [32:0] acc_a;
  logic signed [33:0] acc_b;
  logic signed [ACC_W-1:0] zacc;
  logic signed [ACC_W-1:0] uacc;
  logic signed [ACC_W-1:0] vacc;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] len;
  logic signed [15:0] out_z;
  logic signed [15:0] nrm [3];

  // Input fields.
  logic [3:0]  in_point;
  logic signed [15:0] in_height;
  logic signed [15:0] in_rate;
  action_t     in_action;
  logic        in_acc;

  assign in_action = action_t'(s_axis_tuser);
  assign in_point  = s_axis_tdata[3:0];
  assign in_height = s_axis_tdata[19:4];
  assign in_rate   = s_axis_tdata[35:20];
  assign in_acc    = s_axis_tvalid & s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {nrm[2], nrm[1], nrm[0], out_z, pos_v, pos_u};

  // Configuration port.
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CELLS) ? {25'b0, cells} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells <= 7'd16;
    end else if (cfg_wr && paddr[2] == REG_CELLS) begin
      cells <= pwdata[6:0];
    end
  end

  // Effective cell count and clamped vertex coordinate.
  logic [6:0]  coord;
  logic [6:0]  coord_eff;
  always_comb begin
    if (cells == 7'd0) begin
      cells_eff = 7'd1;
    end else if (int'(cells) > GRID_MAX) begin
      cells_eff = 7'(GRID_MAX);
    end else begin
      cells_eff = cells;
    end
    coord     = sel[0] ? lat_row : lat_col;
    coord_eff = (coord > cells_eff) ? cells_eff : coord;
  end

  // Shared units.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  p;
  shu_req_t  shu_req;
  shu_stat_t shu_stat;
  logic [RAD_W-1:0]  shu_num;
  logic [ROOT_W-1:0] shu_den;
  logic [ROOT_W-1:0] shu_res;

  bbpe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  bbpe_shu u_shu (
    .clk  (clk),
    .rst  (rst),
    .req  (shu_req),
    .num  (shu_num),
    .den  (shu_den),
    .stat (shu_stat),
    .res  (shu_res)
  );

  // Single read port into the height and velocity stores.
  logic [3:0] rd_idx;
  logic signed [15:0] h_rd;
  logic signed [15:0] v_rd;
  logic signed [15:0] v_new;
  logic signed [17:0] h_sum;
  logic signed [15:0] h_new;
  assign rd_idx = (state == ST_TICK) ? cnt : {row, cnt[2:1]};
  assign h_rd   = hs[rd_idx];
  assign v_rd   = vs[rd_idx];

  // Tick arithmetic: velocity reversal and saturating height update.
  always_comb begin
    if (h_rd > 16'sd4096 || h_rd < -16'sd4096) begin
      v_new = (v_rd == -16'sd32768) ? 16'sd32767 : -v_rd;
    end else begin
      v_new = v_rd;
    end
    h_sum = 18'(h_rd) + 18'((p + PROD_W'(16384)) >>> 15);
    if (h_sum > 18'sd32767) begin
      h_new = 16'sd32767;
    end else if (h_sum < -18'sd32768) begin
      h_new = -16'sd32768;
    end else begin
      h_new = 16'(h_sum);
    end
  end

  // Basis parameter and its complement.
  logic [15:0] t_val;
  logic [15:0] s_val;
  assign t_val = sel[0] ? pos_v : pos_u;
  assign s_val = 16'(17'd32768 - {1'b0, t_val});

  // Basis write-back values.
  logic signed [PROD_W-1:0] p3;
  logic signed [17:0] b_plain;
  logic signed [17:0] b_three;
  logic signed [35:0] s2x;
  logic signed [35:0] stx;
  logic signed [35:0] t2x;
  logic signed [35:0] d_sum [CTRL_SIDE];
  always_comb begin
    p3      = p + (p <<< 1);
    b_plain = 18'((p + PROD_W'(64'sd536870912)) >>> 30);
    b_three = 18'((p3 + PROD_W'(64'sd536870912)) >>> 30);
    s2x     = 36'(s2);
    stx     = 36'(st);
    t2x     = 36'(t2);
    d_sum[0] = 36'sd16384 - (s2x + (s2x <<< 1));
    d_sum[1] = 36'sd16384 + 3 * (s2x - (stx <<< 1));
    d_sum[2] = 36'sd16384 + 3 * ((stx <<< 1) - t2x);
    d_sum[3] = 36'sd16384 + (t2x + (t2x <<< 1));
  end

  // Slopes, surface height and normal component selection.
  logic signed [ACC_W-1:0] zu_w;
  logic signed [ACC_W-1:0] zv_w;
  logic signed [ACC_W-1:0] z_w;
  logic signed [31:0] zu;
  logic signed [31:0] zv;
  logic signed [31:0] comp;
  logic [30:0] mag;
  logic signed [17:0] qs;
  logic signed [17:0] nval;
  logic signed [15:0] z_sat;
  always_comb begin
    zu_w = (uacc + ACC_W'(131072)) >>> 18;
    zv_w = (vacc + ACC_W'(131072)) >>> 18;
    z_w  = (zacc + ACC_W'(536870912)) >>> 30;
    zu   = 32'(zu_w);
    zv   = 32'(zv_w);
    case (sel)
      2'd0:    comp = zu;
      2'd1:    comp = zv;
      default: comp = 32'sd16777216;
    endcase
    mag  = comp[31] ? 31'(-comp) : 31'(comp);
    qs   = {1'b0, shu_res[16:0]};
    if (comp[31]) begin
      nval = (qs > 18'sd32767) ? 18'sd32767 : qs;
    end else begin
      nval = -qs;
    end
    if (z_w > ACC_W'(32767)) begin
      z_sat = 16'sd32767;
    end else if (z_w < -ACC_W'(32768)) begin
      z_sat = -16'sd32768;
    end else begin
      z_sat = 16'(z_w);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_TICK: begin
        mul_a = MUL_A_W'(v_new);
        mul_b = MUL_B_W'({16'b0, lat_dt});
      end
      ST_BASIS: begin
        case (cnt[2:0])
          3'd0: begin
            mul_a = MUL_A_W'({1'b0, s_val});
            mul_b = MUL_B_W'({1'b0, s_val});
          end
          3'd1: begin
            mul_a = MUL_A_W'({1'b0, t_val});
            mul_b = MUL_B_W'({1'b0, t_val});
          end
          3'd2: begin
            mul_a = MUL_A_W'({1'b0, s_val});
            mul_b = MUL_B_W'({1'b0, t_val});
          end
          3'd3: begin
            mul_a = MUL_A_W'({1'b0, s2});
            mul_b = MUL_B_W'({1'b0, s_val});
          end
          3'd4: begin
            mul_a = MUL_A_W'({1'b0, s2});
            mul_b = MUL_B_W'({1'b0, t_val});
          end
          3'd5: begin
            mul_a = MUL_A_W'({1'b0, t2});
            mul_b = MUL_B_W'({1'b0, s_val});
          end
          default: begin
            mul_a = MUL_A_W'({1'b0, t2});
            mul_b = MUL_B_W'({1'b0, t_val});
          end
        endcase
      end
      ST_ROWS: begin
        if (cnt < 4'd8) begin
          mul_a = MUL_A_W'(h_rd);
          mul_b = cnt[0] ? MUL_B_W'(bas_d[0][cnt[2:1]]) : MUL_B_W'(bas_b[0][cnt[2:1]]);
        end else if (cnt == 4'd8) begin
          mul_a = MUL_A_W'(acc_a);
          mul_b = MUL_B_W'(bas_b[1][row]);
        end else if (cnt == 4'd9) begin
          mul_a = MUL_A_W'(acc_b);
          mul_b = MUL_B_W'(bas_b[1][row]);
        end else begin
          mul_a = MUL_A_W'(acc_a);
          mul_b = MUL_B_W'(bas_d[1][row]);
        end
      end
      ST_SQUARE: begin
        mul_a = cnt[0] ? MUL_A_W'(zv) : MUL_A_W'(zu);
        mul_b = cnt[0] ? zv : zu;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shift-subtract unit requests.
  always_comb begin
    shu_req.start     = ((state == ST_DIVUV) || (state == ST_SQRT) || (state == ST_NORM))
                        && !phase;
    shu_req.sqrt_mode = (state == ST_SQRT);
    case (state)
      ST_DIVUV: begin
        shu_num = RAD_W'({coord_eff, 15'b0}) + RAD_W'(cells_eff[6:1]);
        shu_den = ROOT_W'(cells_eff);
      end
      ST_SQRT: begin
        shu_num = rad;
        shu_den = len;
      end
      default: begin
        shu_num = RAD_W'({mag, 15'b0}) + RAD_W'(len[ROOT_W-1:1]);
        shu_den = len;
      end
    endcase
  end

  // Control point stores: load writes one point, tick sweeps all sixteen.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NPTS; k++) begin
        hs[k] <= '0;
        vs[k] <= '0;
      end
    end else if (in_acc && in_action == ACT_LOAD) begin
      hs[in_point] <= in_height;
      vs[in_point] <= in_rate;
    end else if (state == ST_TICK) begin
      if (!phase) begin
        vs[rd_idx] <= v_new;
      end else begin
        hs[rd_idx] <= h_new;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
      cnt   <= '0;
      row   <= '0;
      sel   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          phase <= 1'b0;
          cnt   <= '0;
          row   <= '0;
          sel   <= '0;
          if (in_acc && in_action == ACT_TICK) begin
            state <= ST_TICK;
          end else if (in_acc && in_action == ACT_EVAL) begin
            state <= ST_DIVUV;
          end
        end
        ST_TICK: begin
          phase <= ~phase;
          if (phase) begin
            cnt <= cnt + 4'd1;
            if (cnt == 4'(NPTS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DIVUV: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (shu_stat.done) begin
            phase <= 1'b0;
            if (sel[0]) begin
              sel   <= '0;
              cnt   <= '0;
              state <= ST_BASIS;
            end else begin
              sel <= 2'd1;
            end
          end
        end
        ST_BASIS: begin
          phase <= ~phase;
          if (phase) begin
            if (cnt == 4'd6) begin
              cnt <= '0;
              if (sel[0]) begin
                sel   <= '0;
                row   <= '0;
                state <= ST_ROWS;
              end else begin
                sel <= 2'd1;
              end
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        ST_ROWS: begin
          phase <= ~phase;
          if (phase) begin
            if (cnt == 4'd10) begin
              cnt <= '0;
              row <= row + 2'd1;
              if (row == 2'(CTRL_SIDE - 1)) begin
                state <= ST_SQUARE;
              end
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        ST_SQUARE: begin
          phase <= ~phase;
          if (phase) begin
            if (cnt[0]) begin
              cnt   <= '0;
              state <= ST_SQRT;
            end else begin
              cnt <= 4'd1;
            end
          end
        end
        ST_SQRT: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (shu_stat.done) begin
            phase <= 1'b0;
            sel   <= '0;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (shu_stat.done) begin
            phase <= 1'b0;
            if (sel == 2'd2) begin
              sel   <= '0;
              state <= ST_OUT;
            end else begin
              sel <= sel + 2'd1;
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers written back under the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lat_col <= s_axis_tdata[58:52];
      lat_row <= s_axis_tdata[65:59];
      lat_dt  <= s_axis_tdata[51:36];
    end
    case (state)
      ST_DIVUV: begin
        if (phase && shu_stat.done) begin
          if (sel[0]) begin
            pos_v <= shu_res[15:0];
          end else begin
            pos_u <= shu_res[15:0];
          end
        end
      end
      ST_BASIS: begin
        if (phase) begin
          case (cnt[2:0])
            3'd0: s2 <= 31'(p);
            3'd1: t2 <= 31'(p);
            3'd2: st <= 31'(p);
            3'd3: bas_b[sel[0]][0] <= b_plain;
            3'd4: bas_b[sel[0]][1] <= b_three;
            3'd5: bas_b[sel[0]][2] <= b_three;
            default: begin
              bas_b[sel[0]][3] <= b_plain;
              for (int k = 0; k < CTRL_SIDE; k++) begin
                bas_d[sel[0]][k] <= 18'(d_sum[k] >>> 15);
              end
              zacc <= '0;
              uacc <= '0;
              vacc <= '0;
            end
          endcase
        end
      end
      ST_ROWS: begin
        if (phase) begin
          if (cnt < 4'd8) begin
            if (cnt[0]) begin
              acc_b <= ((cnt == 4'd1) ? 34'sd0 : acc_b) + 34'(p);
            end else begin
              acc_a <= ((cnt == 4'd0) ? 33'sd0 : acc_a) + 33'(p);
            end
          end else if (cnt == 4'd8) begin
            zacc <= zacc + ACC_W'(p);
          end else if (cnt == 4'd9) begin
            uacc <= uacc + ACC_W'(p);
          end else begin
            vacc <= vacc + ACC_W'(p);
          end
        end
      end
      ST_SQUARE: begin
        if (phase) begin
          if (cnt[0]) begin
            rad <= rad + RAD_W'(p) + (RAD_W'(1) << 48);
          end else begin
            rad <= RAD_W'(p);
          end
          out_z <= z_sat;
        end
      end
      ST_SQRT: begin
        if (phase && shu_stat.done) begin
          len <= shu_res;
        end
      end
      ST_NORM: begin
        if (phase && shu_stat.done) begin
          nrm[sel] <= 16'(nval);
        end
      end
      default: begin
      end
    endcase
  end

  // A pending result holds off new items.
  `BBPE_ASSERT_IMP(a_out_blocks_in, clk, rst, m_axis_tvalid, !s_axis_tready)
  // The shift-subtract unit is only started when it is free.
  `BBPE_ASSERT_IMP(a_shu_free, clk, rst, shu_req.start, !shu_stat.busy)
  // The normal always points downwards.
  `BBPE_ASSERT_IMP(a_nz_neg, clk, rst, m_axis_tvalid, m_axis_tdata[95])
  // The tick sweep ends after the last control point.
  `BBPE_ASSERT_NEXT(a_tick_end, clk, rst, state == ST_TICK && phase && cnt == 4'd15, state == ST_IDLE)

endmodule

// ===== src/bbpe_mul.sv =====
// Shared signed multiplier with a registered product.
module bbpe_mul (
  input  logic                                  clk,
  input  logic signed [bbpe_pkg::MUL_A_W-1:0]   a,
  input  logic signed [bbpe_pkg::MUL_B_W-1:0]   b,
  output logic signed [bbpe_pkg::PROD_W-1:0]    p
);
  import bbpe_pkg::*;

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ===== src/bbpe_shu.sv =====
// Bit-serial shift-subtract unit: restoring division or integer square root.
module bbpe_shu (
  input  logic                              clk,
  input  logic                              rst,
  input  bbpe_pkg::shu_req_t                req,
  input  logic [bbpe_pkg::RAD_W-1:0]        num,
  input  logic [bbpe_pkg::ROOT_W-1:0]       den,
  output bbpe_pkg::shu_stat_t               stat,
  output logic [bbpe_pkg::ROOT_W-1:0]       res
);
  import bbpe_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [RAD_W-1:0]  src;
  logic [ROOT_W-1:0] den_r;
  logic [4:0]        cnt;
  logic              sqrt_mode;
  logic [REM_W-1:0]  sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              take;

  // One result bit per cycle: shift in one or two source bits and try a subtract.
  always_comb begin
    if (sqrt_mode) begin
      sh    = {rem[REM_W-3:0], src[RAD_W-1:RAD_W-2]};
      trial = REM_W'({res, 2'b01});
    end else begin
      sh    = {rem[REM_W-2:0], src[RAD_W-1]};
      trial = REM_W'(den_r);
    end
    diff = {1'b0, sh} - {1'b0, trial};
    take = ~diff[REM_W];
  end

  // Control: busy while counting steps, done pulses with the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (req.start) begin
        stat.busy <= 1'b1;
        cnt       <= req.sqrt_mode ? 5'(ROOT_W) : 5'(QUO_W);
      end else if (stat.busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder, remaining source bits and the result.
  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_mode <= req.sqrt_mode;
      den_r     <= den;
      res       <= '0;
      if (req.sqrt_mode) begin
        rem <= '0;
        src <= num;
      end else begin
        rem <= REM_W'(num[46:16]);
        src <= {num[15:0], 46'b0};
      end
    end else if (stat.busy) begin
      rem <= take ? diff[REM_W-1:0] : sh;
      res <= {res[ROOT_W-2:0], take};
      src <= sqrt_mode ? {src[RAD_W-3:0], 2'b00} : {src[RAD_W-2:0], 1'b0};
    end
  end

endmodule
